FILE: rtl/vtie_pkg.sv
// shared types, widths and constants of the visible tile index enumerator
// the tile size ladder and the per-size cell counts live here as functions
// no dependencies
`default_nettype none

package vtie_pkg;

   localparam int MAX_TILES_DEF = 64;

   localparam int CODE_W     = 3;
   localparam int SOUTH_W    = 28;
   localparam int WEST_W     = 29;
   localparam int DIVIDEND_W = 31;
   localparam int MAG_W      = 30;
   localparam int DIVISOR_W  = 20;
   localparam int QMAG_W     = 17;
   localparam int QOUT_W     = 18;
   localparam int ROW_W      = 15;
   localparam int COL_W      = 17;
   localparam int FOLD_W     = 18;
   localparam int CELLS_W    = 16;
   localparam int OUT_COL_W  = 16;

   localparam logic signed [DIVIDEND_W-1:0] FULL_TURN = 31'sd360000000;

   localparam logic [1:0] SEL_SOUTH = 2'd0;
   localparam logic [1:0] SEL_WEST  = 2'd1;
   localparam logic [1:0] SEL_NORTH = 2'd2;
   localparam logic [1:0] SEL_EAST  = 2'd3;

   typedef struct packed {
      logic       capture;
      logic       div_start;
      logic [1:0] div_sel;
      logic       fold_init;
      logic       fold_step;
      logic       scan_init;
      logic       emit_tile;
      logic       emit_empty;
   } vtie_cmd_type;

   typedef struct packed {
      logic size_unset;
      logic div_done;
      logic range_empty;
      logic fold_ok;
      logic last_tile;
   } vtie_sts_type;

   // tile edge in microdegrees
   function automatic logic [DIVISOR_W-1:0] tile_udeg(input logic [CODE_W-1:0] code);
      logic [DIVISOR_W-1:0] t;
      case (code)
         3'd1:    t = 20'd10000;
         3'd2:    t = 20'd20000;
         3'd3:    t = 20'd50000;
         3'd4:    t = 20'd100000;
         3'd5:    t = 20'd200000;
         3'd6:    t = 20'd500000;
         3'd7:    t = 20'd1000000;
         default: t = '0;
      endcase
      return t;
   endfunction

   // tiles around a full turn
   function automatic logic [CELLS_W-1:0] turn_cells(input logic [CODE_W-1:0] code);
      logic [CELLS_W-1:0] c;
      case (code)
         3'd1:    c = 16'd36000;
         3'd2:    c = 16'd18000;
         3'd3:    c = 16'd7200;
         3'd4:    c = 16'd3600;
         3'd5:    c = 16'd1800;
         3'd6:    c = 16'd720;
         3'd7:    c = 16'd360;
         default: c = 16'd2;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/vtie_fdiv.sv
// serial floor divider, one quotient bit per cycle over the magnitude
// signed dividend, unsigned nonzero divisor, floor-rounded signed quotient
// depends on vtie_pkg
`default_nettype none

module vtie_fdiv
   import vtie_pkg::*;
(
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start_div,
   input  wire logic signed [DIVIDEND_W-1:0] dividend,
   input  wire logic [DIVISOR_W-1:0]         divisor,
   output logic                              done,
   output logic signed [QOUT_W-1:0]          quotient
);

   localparam int DSH_W = DIVISOR_W + QMAG_W - 1;
   localparam int CNT_W = $clog2(QMAG_W);

   logic [MAG_W-1:0]           rem_ff, rem_in;
   logic [DSH_W-1:0]           dsh_ff, dsh_in;
   logic [QMAG_W-1:0]          q_ff, q_in;
   logic                       neg_ff, neg_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic                       run_ff, run_in;
   logic                       done_ff, done_in;
   logic [DSH_W-1:0]           rem_ext;
   logic [DSH_W-1:0]           diff;
   logic                       fits;
   logic signed [DIVIDEND_W-1:0] mag_full;
   logic [QOUT_W-1:0]          q_ext;

   assign rem_ext  = {{(DSH_W-MAG_W){1'b0}}, rem_ff};
   assign fits     = rem_ext >= dsh_ff;
   assign diff     = rem_ext - dsh_ff;
   assign mag_full = dividend[DIVIDEND_W-1] ? -dividend : dividend;

   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      q_in    = q_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start_div) begin
         rem_in = mag_full[MAG_W-1:0];
         dsh_in = {divisor, {(QMAG_W-1){1'b0}}};
         q_in   = '0;
         neg_in = dividend[DIVIDEND_W-1];
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (fits) begin
            rem_in = diff[MAG_W-1:0];
         end
         q_in   = {q_ff[QMAG_W-2:0], fits};
         dsh_in = dsh_ff >> 1;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(QMAG_W-1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      q_ff   <= q_in;
      neg_ff <= neg_in;
   end

   // negative: -q when exact, -q-1 (= ~q) otherwise
   assign q_ext = {1'b0, q_ff};
   always_comb begin
      if (!neg_ff) begin
         quotient = $signed(q_ext);
      end else if (rem_ff != '0) begin
         quotient = $signed(~q_ext);
      end else begin
         quotient = $signed(~q_ext + 1'b1);
      end
   end

   assign done = done_ff;

endmodule

`default_nettype wire

FILE: rtl/vtie_dp.sv
// datapath: size register, captured viewport, divider, scan bounds and cursors
// column folding and result registers; driven by vtie_ctrl commands
// depends on vtie_pkg and vtie_fdiv
`default_nettype none

module vtie_dp
   import vtie_pkg::*;
#(
   parameter int MAX_TILES = MAX_TILES_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire vtie_cmd_type             cmd,
   output vtie_sts_type                  sts,
   input  wire logic                     csr_we,
   input  wire logic [CODE_W-1:0]        csr_wdata,
   input  wire logic signed [SOUTH_W-1:0] req_view_south,
   input  wire logic signed [WEST_W-1:0]  req_view_west,
   input  wire logic signed [SOUTH_W-1:0] req_view_north,
   input  wire logic signed [WEST_W-1:0]  req_view_east,
   output logic                          rsp_valid,
   output logic signed [ROW_W-1:0]       rsp_tile_row,
   output logic signed [OUT_COL_W-1:0]   rsp_tile_col,
   output logic                          rsp_empty_res,
   output logic                          rsp_truncated,
   output logic                          rsp_last
);

   localparam int CNT_W = $clog2(MAX_TILES);

   logic [CODE_W-1:0]             code_ff;
   logic signed [DIVIDEND_W-1:0]  south_ff, west_ff, north_ff, east_ff;
   logic signed [DIVIDEND_W-1:0]  west_ext, east_ext, east_unw;
   logic signed [DIVIDEND_W-1:0]  dividend;
   logic                          div_done;
   logic signed [QOUT_W-1:0]      quot;
   logic signed [ROW_W-1:0]       row_cursor_ff, row_end_ff;
   logic signed [COL_W-1:0]       col_start_ff, col_end_ff, col_cursor_ff;
   logic signed [FOLD_W-1:0]      fstart_ff, fcur_ff;
   logic [CNT_W-1:0]              count_ff;
   logic signed [FOLD_W-1:0]      cells, half, neg_half;
   logic                          at_end, cap_hit;
   logic                          valid_ff, empty_ff, trunc_ff, last_ff;
   logic signed [ROW_W-1:0]       tile_row_ff;
   logic signed [OUT_COL_W-1:0]   tile_col_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         code_ff <= '0;
      end else if (csr_we) begin
         code_ff <= csr_wdata;
      end
   end

   // unwrap east edge across the antimeridian
   assign west_ext = DIVIDEND_W'(req_view_west);
   assign east_ext = DIVIDEND_W'(req_view_east);
   assign east_unw = (east_ext < west_ext) ? east_ext + FULL_TURN : east_ext;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         south_ff <= DIVIDEND_W'(req_view_south);
         north_ff <= DIVIDEND_W'(req_view_north);
         west_ff  <= west_ext;
         east_ff  <= east_unw;
      end
   end

   always_comb begin
      case (cmd.div_sel)
         SEL_SOUTH: dividend = south_ff;
         SEL_WEST:  dividend = west_ff;
         SEL_NORTH: dividend = north_ff;
         SEL_EAST:  dividend = east_ff;
         default:   dividend = south_ff;
      endcase
   end

   vtie_fdiv u_fdiv (
      .clock     (clock),
      .reset     (reset),
      .start_div (cmd.div_start),
      .dividend  (dividend),
      .divisor   (tile_udeg(code_ff)),
      .done      (div_done),
      .quotient  (quot)
   );

   assign cells    = $signed({{(FOLD_W-CELLS_W){1'b0}}, turn_cells(code_ff)});
   assign half     = cells >>> 1;
   assign neg_half = -half;

   assign at_end  = (row_cursor_ff == row_end_ff) && (col_cursor_ff == col_end_ff);
   assign cap_hit = count_ff == CNT_W'(MAX_TILES - 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.scan_init) begin
         count_ff <= '0;
      end else if (cmd.emit_tile) begin
         count_ff <= count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (div_done) begin
         case (cmd.div_sel)
            SEL_SOUTH: row_cursor_ff <= quot[ROW_W-1:0];
            SEL_NORTH: row_end_ff    <= quot[ROW_W-1:0];
            SEL_WEST:  col_start_ff  <= quot[COL_W-1:0];
            SEL_EAST:  col_end_ff    <= quot[COL_W-1:0];
            default:   row_cursor_ff <= quot[ROW_W-1:0];
         endcase
      end else if (cmd.emit_tile && (col_cursor_ff == col_end_ff)) begin
         row_cursor_ff <= row_cursor_ff + 1'b1;
      end

      if (cmd.fold_init) begin
         fstart_ff <= FOLD_W'(col_start_ff);
      end else if (cmd.fold_step) begin
         fstart_ff <= (fstart_ff >= half) ? fstart_ff - cells : fstart_ff + cells;
      end

      if (cmd.scan_init) begin
         col_cursor_ff <= col_start_ff;
         fcur_ff       <= fstart_ff;
      end else if (cmd.emit_tile) begin
         if (col_cursor_ff == col_end_ff) begin
            col_cursor_ff <= col_start_ff;
            fcur_ff       <= fstart_ff;
         end else begin
            col_cursor_ff <= col_cursor_ff + 1'b1;
            fcur_ff       <= (fcur_ff == half - 1'b1) ? neg_half : fcur_ff + 1'b1;
         end
      end
   end

   // result registers, one beat per strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= cmd.emit_tile | cmd.emit_empty;
      end
      if (cmd.emit_empty) begin
         tile_row_ff <= '0;
         tile_col_ff <= '0;
         empty_ff    <= 1'b1;
         trunc_ff    <= 1'b0;
         last_ff     <= 1'b1;
      end else if (cmd.emit_tile) begin
         tile_row_ff <= row_cursor_ff;
         tile_col_ff <= fcur_ff[OUT_COL_W-1:0];
         empty_ff    <= 1'b0;
         trunc_ff    <= cap_hit && !at_end;
         last_ff     <= cap_hit || at_end;
      end
   end

   assign sts.size_unset  = code_ff == '0;
   assign sts.div_done    = div_done;
   assign sts.range_empty = (row_end_ff < row_cursor_ff) || (col_end_ff < col_start_ff);
   assign sts.fold_ok     = (fstart_ff >= neg_half) && (fstart_ff < half);
   assign sts.last_tile   = at_end || cap_hit;

   assign rsp_valid     = valid_ff;
   assign rsp_tile_row  = tile_row_ff;
   assign rsp_tile_col  = tile_col_ff;
   assign rsp_empty_res = empty_ff;
   assign rsp_truncated = trunc_ff;
   assign rsp_last      = last_ff;

endmodule

`default_nettype wire

FILE: rtl/vtie_ctrl.sv
// controller state machine: sequences capture, four divisions, range check,
// column fold and the tile scan; depends on vtie_pkg
`default_nettype none

module vtie_ctrl
   import vtie_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic         view_ready,
   output logic              busy,
   output vtie_cmd_type      cmd,
   input  wire vtie_sts_type sts
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_EMPTY  = 3'd1;
   localparam logic [2:0] ST_DSTART = 3'd2;
   localparam logic [2:0] ST_DWAIT  = 3'd3;
   localparam logic [2:0] ST_CHECK  = 3'd4;
   localparam logic [2:0] ST_FOLD   = 3'd5;
   localparam logic [2:0] ST_EMIT   = 3'd6;

   logic [2:0] state_ff, state_in;
   logic [1:0] sel_ff, sel_in;

   always_comb begin
      state_in = state_ff;
      sel_in   = sel_ff;
      cmd      = '0;
      cmd.div_sel = sel_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               sel_in      = SEL_SOUTH;
               state_in    = (sts.size_unset || !view_ready) ? ST_EMPTY : ST_DSTART;
            end
         end
         ST_EMPTY: begin
            cmd.emit_empty = 1'b1;
            state_in       = ST_IDLE;
         end
         ST_DSTART: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DWAIT;
         end
         ST_DWAIT: begin
            if (sts.div_done) begin
               if (sel_ff == SEL_EAST) begin
                  state_in = ST_CHECK;
               end else begin
                  sel_in   = sel_ff + 1'b1;
                  state_in = ST_DSTART;
               end
            end
         end
         ST_CHECK: begin
            if (sts.range_empty) begin
               state_in = ST_EMPTY;
            end else begin
               cmd.fold_init = 1'b1;
               state_in      = ST_FOLD;
            end
         end
         ST_FOLD: begin
            if (sts.fold_ok) begin
               cmd.scan_init = 1'b1;
               state_in      = ST_EMIT;
            end else begin
               cmd.fold_step = 1'b1;
            end
         end
         ST_EMIT: begin
            cmd.emit_tile = 1'b1;
            if (sts.last_tile) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sel_ff   <= SEL_SOUTH;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
      end
   end

   assign busy = state_ff != ST_IDLE;

endmodule

`default_nettype wire

FILE: rtl/visible_tile_index_enumerator.sv
// top level of the visible tile index enumerator
// joins the controller vtie_ctrl and the datapath vtie_dp; depends on vtie_pkg
`default_nettype none

// A viewport is taken when start is high and busy low. Its tiles come out one
// beat per cycle on rsp_valid, latitude rows first, columns west to east, the
// final beat marked by rsp_last; a run stops after MAX_TILES beats, with
// rsp_truncated set if tiles remain. An unset tile size, a viewport that is
// not ready or an empty latitude range gives a single beat with rsp_empty_res
// set. The receiver cannot stall: every beat is shown for exactly one cycle.
// Each viewport with a set size that is ready first runs four floor divisions
// through one serial divider at one quotient bit per cycle, then a range check
// and the column fold, then the tile scan; the final beat shows in the first
// cycle with busy low. An unset size or a viewport that is not ready skips the
// divisions and goes straight to the empty beat.
module visible_tile_index_enumerator
   import vtie_pkg::*;
#(
   parameter int MAX_TILES = MAX_TILES_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_we,
   input  wire logic [CODE_W-1:0]         csr_wdata,
   input  wire logic                      start,
   output logic                           busy,
   input  wire logic signed [SOUTH_W-1:0] req_view_south,
   input  wire logic signed [WEST_W-1:0]  req_view_west,
   input  wire logic signed [SOUTH_W-1:0] req_view_north,
   input  wire logic signed [WEST_W-1:0]  req_view_east,
   input  wire logic                      req_view_ready,
   output logic                           rsp_valid,
   output logic signed [ROW_W-1:0]        rsp_tile_row,
   output logic signed [OUT_COL_W-1:0]    rsp_tile_col,
   output logic                           rsp_empty_res,
   output logic                           rsp_truncated,
   output logic                           rsp_last
);

   vtie_cmd_type cmd;
   vtie_sts_type sts;

   vtie_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .view_ready (req_view_ready),
      .busy       (busy),
      .cmd        (cmd),
      .sts        (sts)
   );

   vtie_dp #(
      .MAX_TILES (MAX_TILES)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .req_view_south (req_view_south),
      .req_view_west  (req_view_west),
      .req_view_north (req_view_north),
      .req_view_east  (req_view_east),
      .rsp_valid      (rsp_valid),
      .rsp_tile_row   (rsp_tile_row),
      .rsp_tile_col   (rsp_tile_col),
      .rsp_empty_res  (rsp_empty_res),
      .rsp_truncated  (rsp_truncated),
      .rsp_last       (rsp_last)
   );

endmodule

`default_nettype wire
